FILE: hw/rtl/s3cp_pkg.sv
package s3cp_pkg;

    localparam int S3CP_NUM_SYMBOLS = 7;
    localparam int S3CP_CODE_W      = 3;
    localparam int S3CP_BYTE_W      = 8;
    localparam int S3CP_CFG_IDX_W   = 3;
    localparam int S3CP_QUEUE_DEPTH = 4;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic                   operation;
        logic [S3CP_BYTE_W-1:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic [S3CP_BYTE_W-1:0] packed_byte;
        logic                   last_of_run;
    } t_out_word;

    // one queue entry: one or two finished bytes from a single input word
    typedef struct packed {
        logic                   pair;
        logic [S3CP_BYTE_W-1:0] byte0;
        logic [S3CP_BYTE_W-1:0] byte1;
    } t_pack_entry;

    typedef struct packed {
        logic        empty;
        t_pack_entry head;
    } t_queue_status;

endpackage

FILE: hw/rtl/s3cp_front.sv
module s3cp_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [s3cp_pkg::S3CP_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [s3cp_pkg::S3CP_BYTE_W-1:0]       i_cfg_data,
    input  logic                                   i_accept,
    input  s3cp_pkg::t_in_word                     i_word,
    output logic                                   o_push,
    output s3cp_pkg::t_pack_entry                  o_entry
);
    import s3cp_pkg::*;

    logic [S3CP_BYTE_W-1:0] r_symtab [S3CP_NUM_SYMBOLS];
    logic [S3CP_BYTE_W-1:0] r_part, n_part;
    logic [2:0]             r_pos, n_pos;
    logic [S3CP_CODE_W-1:0] code;
    logic                   emit;
    t_pack_entry            entry;

    // lowest matching index wins, no match gives code 0
    always_comb begin
        code = '0;
        for (int i = S3CP_NUM_SYMBOLS - 1; i >= 0; i--) begin
            if (r_symtab[i] == i_word.symbol) begin
                code = S3CP_CODE_W'(i);
            end
        end
    end

    always_comb begin
        emit         = 1'b0;
        entry.pair   = 1'b0;
        entry.byte0  = '0;
        entry.byte1  = '0;
        n_part       = r_part;
        n_pos        = r_pos + 3'd1;
        if (i_word.operation == OP_FLUSH) begin
            n_part = '0;
            n_pos  = '0;
            emit   = 1'b1;
            unique case (r_pos)
                3'd0: emit = 1'b0;
                3'd1: entry.byte0 = r_part | 8'h1C;
                3'd2: begin
                    entry.byte0 = r_part | 8'h03;
                    entry.byte1 = 8'h80;
                    entry.pair  = 1'b1;
                end
                3'd3: entry.byte0 = r_part | 8'h7F;
                3'd4: entry.byte0 = r_part | 8'h0F;
                3'd5: begin
                    entry.byte0 = r_part | 8'h01;
                    entry.byte1 = 8'hC0;
                    entry.pair  = 1'b1;
                end
                3'd6: entry.byte0 = r_part | 8'h3F;
                3'd7: entry.byte0 = r_part | 8'h07;
                default: emit = 1'b0;
            endcase
        end else begin
            unique case (r_pos)
                3'd0: n_part = {code, 5'b0};
                3'd1: n_part = r_part | {3'b0, code, 2'b0};
                3'd2: begin
                    emit        = 1'b1;
                    entry.byte0 = r_part | {6'b0, code[2:1]};
                    n_part      = {code[0], 7'b0};
                end
                3'd3: n_part = r_part | {1'b0, code, 4'b0};
                3'd4: n_part = r_part | {4'b0, code, 1'b0};
                3'd5: begin
                    emit        = 1'b1;
                    entry.byte0 = r_part | {7'b0, code[2]};
                    n_part      = {code[1:0], 6'b0};
                end
                3'd6: n_part = r_part | {2'b0, code, 3'b0};
                3'd7: begin
                    emit        = 1'b1;
                    entry.byte0 = r_part | {5'b0, code};
                    n_part      = '0;
                end
                default: n_part = r_part;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_pos  <= '0;
            for (int i = 0; i < S3CP_NUM_SYMBOLS; i++) begin
                r_symtab[i] <= '0;
            end
        end else begin
            if (i_accept) begin
                r_part <= n_part;
                r_pos  <= n_pos;
            end
            for (int i = 0; i < S3CP_NUM_SYMBOLS; i++) begin
                if (i_cfg_we && i_cfg_index == S3CP_CFG_IDX_W'(i)) begin
                    r_symtab[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_push  = i_accept && emit;
    assign o_entry = entry;

endmodule

FILE: hw/rtl/s3cp_queue.sv
module s3cp_queue #(
    parameter int DEPTH = s3cp_pkg::S3CP_QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  s3cp_pkg::t_pack_entry   i_entry,
    input  logic                    i_pop,
    output logic                    o_full,
    output s3cp_pkg::t_queue_status o_status
);
    import s3cp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pack_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full          = (r_count == CNT_W'(DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_mem[r_rd_ptr];
    assign do_push         = i_push && !o_full;
    assign do_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/s3cp_back.sv
module s3cp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  s3cp_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output s3cp_pkg::t_out_word     o_word
);
    import s3cp_pkg::*;

    logic      r_valid;
    logic      r_second;
    t_out_word r_word;
    logic      load_ok;

    assign load_ok = !r_valid || !i_stall;
    // an entry leaves the queue once its last byte is loaded
    assign o_pop   = load_ok && !i_status.empty && (r_second || !i_status.head.pair);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load_ok) begin
            r_valid <= !i_status.empty;
            if (!i_status.empty) begin
                r_second <= i_status.head.pair && !r_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && !i_status.empty) begin
            if (r_second) begin
                r_word.packed_byte <= i_status.head.byte1;
                r_word.last_of_run <= 1'b1;
            end else begin
                r_word.packed_byte <= i_status.head.byte0;
                r_word.last_of_run <= !i_status.head.pair;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hw/rtl/symbol_to_3bit_code_packer.sv
// path: a finished word is written into the queue, then loaded into the output register;
// the second word of a two-word flush is loaded into the output register after the first
// throughput: one input word per cycle while the queue is not full; the output drains
// one word per cycle unless stalled; a two-word flush stays queued until both are loaded
// reset: synchronous active-low, clears the symbol table, packing state and queue
module symbol_to_3bit_code_packer #(
    parameter int QUEUE_DEPTH = s3cp_pkg::S3CP_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [s3cp_pkg::S3CP_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [s3cp_pkg::S3CP_BYTE_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  s3cp_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output s3cp_pkg::t_out_word                 o_out_word
);
    import s3cp_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    logic          full;
    t_pack_entry   entry;
    t_queue_status status;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    s3cp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_push      (push),
        .o_entry     (entry)
    );

    s3cp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_full   (full),
        .o_status (status)
    );

    s3cp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_out_word)
    );

endmodule
